// File: sv/mlh_pkg.sv
package mlh_pkg;

	localparam int ItemBits = 60;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_CLOSE = 2'd1;
	localparam logic [1:0] OP_OPEN  = 2'd2;

	localparam logic [1:0] RS_NONE   = 2'd0;
	localparam logic [1:0] RS_PACKET = 2'd1;
	localparam logic [1:0] RS_FAIL   = 2'd2;

	localparam logic [3:0] PK_DMR       = 4'd0;
	localparam logic [3:0] PK_P25       = 4'd1;
	localparam logic [3:0] PK_WL_RID    = 4'd2;
	localparam logic [3:0] PK_BL_RID    = 4'd3;
	localparam logic [3:0] PK_ACT_TG    = 4'd4;
	localparam logic [3:0] PK_DEACT_TG  = 4'd5;
	localparam logic [3:0] PK_NAK       = 4'd6;
	localparam logic [3:0] PK_ACK       = 4'd7;
	localparam logic [3:0] PK_CLOSING   = 4'd8;
	localparam logic [3:0] PK_PONG      = 4'd9;

	localparam logic [2:0] ST_WAIT_CONNECT = 3'd0;
	localparam logic [2:0] ST_WAIT_LOGIN   = 3'd1;
	localparam logic [2:0] ST_WAIT_AUTH    = 3'd2;
	localparam logic [2:0] ST_WAIT_CONFIG  = 3'd3;
	localparam logic [2:0] ST_RUNNING      = 3'd4;

	localparam logic [2:0] CFG_RETRY_PERIOD   = 3'd0;
	localparam logic [2:0] CFG_TIMEOUT_PERIOD = 3'd1;
	localparam logic [2:0] CFG_NET_EN         = 3'd2;
	localparam logic [2:0] CFG_DMR_EN         = 3'd3;
	localparam logic [2:0] CFG_P25_EN         = 3'd4;
	localparam logic [2:0] CFG_LOOKUP_EN      = 3'd5;

	localparam logic [15:0] RETRY_PERIOD_RESET   = 16'd10000;
	localparam logic [15:0] TIMEOUT_PERIOD_RESET = 16'd60000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] ack_salt;
		logic        lookup_ok;
		logic        login_write_ok;
		logic        socket_open_ok;
		logic        source_ok;
		logic [3:0]  packet_kind;
		logic [1:0]  read_status;
		logic [15:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [31:0] auth_salt;
		logic [2:0]  link_status;
		logic        invalid_source;
		logic        link_reset;
		logic        apply_list_update;
		logic        forward_p25;
		logic        forward_dmr;
		logic        send_closing;
		logic        send_ping;
		logic        send_config;
		logic        send_auth;
		logic        send_login;
	} result_t;

	typedef struct packed {
		logic [15:0] retry_period_ms;
		logic [15:0] timeout_period_ms;
		logic        net_enabled;
		logic        dmr_enabled;
		logic        p25_enabled;
		logic        lookup_update_enabled;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  link_state;
		logic        retry_run;
		logic [15:0] retry_cnt;
		logic        tmo_run;
		logic [15:0] tmo_cnt;
		logic [31:0] salt;
	} link_t;

endpackage

// File: sv/mlh_step.sv
module mlh_step (
	input  mlh_pkg::item_t   item,
	input  mlh_pkg::link_t   cur,
	input  mlh_pkg::cfg_t    cfg,
	output mlh_pkg::link_t   nxt,
	output mlh_pkg::result_t res
);

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	function automatic logic expired(input logic run, input logic [15:0] cnt,
			input logic [15:0] period);
		return run && (period != 16'd0) && (cnt >= period);
	endfunction

	function automatic mlh_pkg::link_t do_close(input mlh_pkg::link_t s);
		mlh_pkg::link_t t;
		t = s;
		t.retry_run  = 1'b0;
		t.retry_cnt  = '0;
		t.tmo_run    = 1'b0;
		t.tmo_cnt    = '0;
		t.link_state = mlh_pkg::ST_WAIT_CONNECT;
		return t;
	endfunction

	function automatic mlh_pkg::link_t do_open(input mlh_pkg::link_t s, input logic ok);
		mlh_pkg::link_t t;
		t = s;
		if (ok) begin
			t.link_state = mlh_pkg::ST_WAIT_CONNECT;
			t.tmo_run    = 1'b0;
			t.tmo_cnt    = '0;
			t.retry_run  = 1'b1;
			t.retry_cnt  = '0;
		end
		return t;
	endfunction

	function automatic mlh_pkg::link_t start_both(input mlh_pkg::link_t s);
		mlh_pkg::link_t t;
		t = s;
		t.tmo_run   = 1'b1;
		t.tmo_cnt   = '0;
		t.retry_run = 1'b1;
		t.retry_cnt = '0;
		return t;
	endfunction

	logic done;
	logic net_ok;

	assign net_ok = cfg.net_enabled;

	always_comb begin
		nxt  = cur;
		res  = '0;
		done = 1'b0;
		unique case (item.op)
			mlh_pkg::OP_TICK: begin
				if (cur.link_state == mlh_pkg::ST_WAIT_CONNECT) begin
					if (nxt.retry_run) begin
						nxt.retry_cnt = sat_add(nxt.retry_cnt, item.elapsed_ms);
					end
					if (expired(nxt.retry_run, nxt.retry_cnt, cfg.retry_period_ms)) begin
						if (item.socket_open_ok) begin
							res.send_login = 1'b1;
							if (!item.login_write_ok) begin
								done = 1'b1;
							end else begin
								nxt.link_state = mlh_pkg::ST_WAIT_LOGIN;
								nxt.tmo_run    = 1'b1;
								nxt.tmo_cnt    = '0;
							end
						end
						if (!done) begin
							nxt.retry_run = 1'b1;
							nxt.retry_cnt = '0;
						end
					end
				end else begin
					if (item.read_status == mlh_pkg::RS_FAIL) begin
						res.send_closing = (nxt.link_state == mlh_pkg::ST_RUNNING);
						nxt = do_open(do_close(nxt), item.lookup_ok);
						res.link_reset = 1'b1;
						done = 1'b1;
					end else if (item.read_status == mlh_pkg::RS_PACKET) begin
						if (!item.source_ok) begin
							res.invalid_source = 1'b1;
							done = 1'b1;
						end else begin
							unique case (item.packet_kind)
								mlh_pkg::PK_DMR: begin
									res.forward_dmr = net_ok && cfg.dmr_enabled;
								end
								mlh_pkg::PK_P25: begin
									res.forward_p25 = net_ok && cfg.p25_enabled;
								end
								mlh_pkg::PK_WL_RID, mlh_pkg::PK_BL_RID,
								mlh_pkg::PK_ACT_TG, mlh_pkg::PK_DEACT_TG: begin
									res.apply_list_update = net_ok && cfg.lookup_update_enabled;
								end
								mlh_pkg::PK_NAK: begin
									if (nxt.link_state == mlh_pkg::ST_RUNNING) begin
										nxt.link_state = mlh_pkg::ST_WAIT_LOGIN;
										nxt = start_both(nxt);
									end else begin
										nxt = do_open(do_close(nxt), item.lookup_ok);
										res.link_reset = 1'b1;
										done = 1'b1;
									end
								end
								mlh_pkg::PK_ACK: begin
									if (nxt.link_state == mlh_pkg::ST_WAIT_LOGIN) begin
										nxt.salt       = item.ack_salt;
										res.send_auth  = 1'b1;
										nxt.link_state = mlh_pkg::ST_WAIT_AUTH;
										nxt = start_both(nxt);
									end else if (nxt.link_state == mlh_pkg::ST_WAIT_AUTH) begin
										res.send_config = 1'b1;
										nxt.link_state  = mlh_pkg::ST_WAIT_CONFIG;
										nxt = start_both(nxt);
									end else if (nxt.link_state == mlh_pkg::ST_WAIT_CONFIG) begin
										nxt.link_state = mlh_pkg::ST_RUNNING;
										nxt = start_both(nxt);
									end
								end
								mlh_pkg::PK_CLOSING: begin
									res.send_closing = (nxt.link_state == mlh_pkg::ST_RUNNING);
									nxt = do_open(do_close(nxt), item.lookup_ok);
									res.link_reset = 1'b1;
								end
								mlh_pkg::PK_PONG: begin
									nxt.tmo_run = 1'b1;
									nxt.tmo_cnt = '0;
								end
								default: begin
								end
							endcase
						end
					end
					if (!done) begin
						if (nxt.retry_run) begin
							nxt.retry_cnt = sat_add(nxt.retry_cnt, item.elapsed_ms);
						end
						if (expired(nxt.retry_run, nxt.retry_cnt, cfg.retry_period_ms)) begin
							priority case (nxt.link_state)
								mlh_pkg::ST_WAIT_LOGIN:  res.send_login  = 1'b1;
								mlh_pkg::ST_WAIT_AUTH:   res.send_auth   = 1'b1;
								mlh_pkg::ST_WAIT_CONFIG: res.send_config = 1'b1;
								mlh_pkg::ST_RUNNING:     res.send_ping   = 1'b1;
								default: begin
								end
							endcase
							nxt.retry_run = 1'b1;
							nxt.retry_cnt = '0;
						end
						if (nxt.tmo_run) begin
							nxt.tmo_cnt = sat_add(nxt.tmo_cnt, item.elapsed_ms);
						end
						if (expired(nxt.tmo_run, nxt.tmo_cnt, cfg.timeout_period_ms)) begin
							if (nxt.link_state == mlh_pkg::ST_RUNNING) begin
								res.send_closing = 1'b1;
							end
							nxt = do_open(do_close(nxt), item.lookup_ok);
							res.link_reset = 1'b1;
						end
					end
				end
			end
			mlh_pkg::OP_CLOSE: begin
				res.send_closing = (cur.link_state == mlh_pkg::ST_RUNNING);
				nxt = do_close(cur);
			end
			mlh_pkg::OP_OPEN: begin
				nxt = do_open(cur, item.lookup_ok);
			end
			default: begin
			end
		endcase
		res.link_status = nxt.link_state;
		res.auth_salt   = nxt.salt;
	end

endmodule

// File: sv/master_link_handshake_fsm_top.sv
// Client-side link controller: one item per clock cycle when neither side stalls. An item is
// held in an input register, decided by single-pass logic against the link state, timers
// and salt, and its one result is loaded into an output register once that register is free
// or being emptied, and is offered from there; while a result waits on m_tready, one more item
// can still enter the input register before s_tready drops.
module master_link_handshake_fsm_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// elapsed_ms, read_status, packet_kind, source_ok, socket_open_ok, login_write_ok,
	// lookup_ok, ack_salt, zero fill.
	input  logic [63:0] s_tdata,
	// op.
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// send_login, send_auth, send_config, send_ping, send_closing, forward_dmr, forward_p25,
	// apply_list_update, link_reset, invalid_source, link_status, auth_salt, zero fill.
	output logic [47:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	mlh_pkg::item_t   item_s1;
	logic             valid_s1;
	mlh_pkg::link_t   link_q;
	mlh_pkg::link_t   link_nxt;
	mlh_pkg::cfg_t    cfg_q;
	mlh_pkg::result_t res_nxt;
	mlh_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= {s_tuser, s_tdata[mlh_pkg::ItemBits-3:0]};
		end
	end

	mlh_step u_step (
		.item (item_s1),
		.cur  (link_q),
		.cfg  (cfg_q),
		.nxt  (link_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q.link_state <= mlh_pkg::ST_WAIT_CONNECT;
			link_q.retry_run  <= 1'b1;
			link_q.retry_cnt  <= '0;
			link_q.tmo_run    <= 1'b0;
			link_q.tmo_cnt    <= '0;
			link_q.salt       <= '0;
		end else if (advance) begin
			link_q <= link_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_period_ms       <= mlh_pkg::RETRY_PERIOD_RESET;
			cfg_q.timeout_period_ms     <= mlh_pkg::TIMEOUT_PERIOD_RESET;
			cfg_q.net_enabled           <= 1'b0;
			cfg_q.dmr_enabled           <= 1'b0;
			cfg_q.p25_enabled           <= 1'b0;
			cfg_q.lookup_update_enabled <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mlh_pkg::CFG_RETRY_PERIOD:   cfg_q.retry_period_ms       <= cfg_data;
				mlh_pkg::CFG_TIMEOUT_PERIOD: cfg_q.timeout_period_ms     <= cfg_data;
				mlh_pkg::CFG_NET_EN:         cfg_q.net_enabled           <= cfg_data[0];
				mlh_pkg::CFG_DMR_EN:         cfg_q.dmr_enabled           <= cfg_data[0];
				mlh_pkg::CFG_P25_EN:         cfg_q.p25_enabled           <= cfg_data[0];
				mlh_pkg::CFG_LOOKUP_EN:      cfg_q.lookup_update_enabled <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/mlh_checker.sv
module mlh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	mlh_pkg::result_t r;

	assign r = m_tdata[$bits(mlh_pkg::result_t)-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result changed while stalled.");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r.link_status <= mlh_pkg::ST_RUNNING)
		else $error("Link status out of range.");

	a_closing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.send_closing |-> r.link_status == mlh_pkg::ST_WAIT_CONNECT)
		else $error("Closing notice without return to wait for connect.");

	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.link_reset |-> r.link_status == mlh_pkg::ST_WAIT_CONNECT)
		else $error("Link reset left the link out of wait for connect.");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.invalid_source |-> m_tdata[8:0] == 9'd0)
		else $error("Dropped packet raised other flags.");

endmodule

bind master_link_handshake_fsm_top mlh_checker u_mlh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
